/* hw/rtl/cxtbc_pkg.sv */
// Shared types and constants for the chained XOR key-table byte cipher.
// Holds the generator constants, the command codes and the word layouts.
// Has no dependencies; imported by the cipher top level and the testbench.
`default_nettype none

package cxtbc_pkg;

  // Park-Miller minimal-standard generator, modulus 2^31-1.
  typedef logic [30:0] pm_word_t;

  localparam longint PM_MODULUS_L = 64'h7fffffff;
  localparam longint PM_MULT_L    = 64'h41a7;
  localparam longint PM_Q_L       = 64'h1f31d;
  localparam longint PM_R_L       = 64'hb14;

  localparam pm_word_t PM_MODULUS = 31'(PM_MODULUS_L);
  localparam int       PM_MULT    = 32'(PM_MULT_L);
  localparam pm_word_t SEED_RESET = 31'h0a2c2a;

  // The Schrage step taken from an all-ones seed does not give the true
  // modular product; this is the value that step produces.
  localparam longint PM_ONES_NEXT_L =
      PM_MULT_L * (PM_MODULUS_L % PM_Q_L) - PM_R_L * (PM_MODULUS_L / PM_Q_L) + PM_MODULUS_L;
  localparam pm_word_t PM_ONES_NEXT = 31'(PM_ONES_NEXT_L);

  // Product of a generator word and the multiplier.
  localparam int PM_PROD_W = 46;

  // Command codes carried in the low bits of the input tuser.
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_ENCIPHER = 2'd0;
  localparam cmd_t CMD_DECIPHER = 2'd1;
  localparam cmd_t CMD_BUILD    = 2'd2;
  localparam cmd_t CMD_NONE     = 2'd3;

  typedef logic [7:0] byte_t;

  // Defaults for the top-level parameters.
  localparam int TABLE_DEPTH_DEF     = 512;
  localparam int TABLE_VALUE_MAX_DEF = 256;

endpackage

`default_nettype wire

/* hw/rtl/chained_xor_table_byte_cipher.sv */
// Top level of the chained XOR key-table byte cipher, with its key memory.
// Depends on cxtbc_pkg for generator constants, command codes and types.
`default_nettype none

// Byte cipher with a key table held in a synchronous memory of TABLE_DEPTH
// bytes. A build word fills the table from a Park-Miller generator started
// at the seed register, taking each entry through the multiply, reduction,
// scale and write states before a (zero) result word ends it, and the table
// must be built before any message byte is sent. Each message byte needs
// two reads of the key memory, which has one read port: when the result
// side keeps up, a byte is accepted, its first key read returns, and its
// second key read returns as the next byte is accepted. A word with the
// unused command yields a zero result. A byte with the first flag set
// clears the chain byte, the table index and the overflow flag. The
// overflow flag in the result tuser reports that the message has run past
// the end of the table and the index has wrapped. The seed register may be
// written only while no word is in flight.
module chained_xor_table_byte_cipher #(
  parameter int TABLE_DEPTH     = cxtbc_pkg::TABLE_DEPTH_DEF,
  parameter int TABLE_VALUE_MAX = cxtbc_pkg::TABLE_VALUE_MAX_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  // Seed register write port.
  input  wire                  cfg_wr_en,
  input  cxtbc_pkg::pm_word_t  cfg_wr_data,   // seed_start
  // Input channel.
  input  wire                  in_tvalid,
  output logic                 in_tready,
  input  cxtbc_pkg::byte_t     in_tdata,      // [7:0] data_byte
  input  wire  [2:0]           in_tuser,      // [1:0] cmd, [2] first
  // Result channel.
  output logic                 out_tvalid,
  input  wire                  out_tready,
  output cxtbc_pkg::byte_t     out_tdata,     // [7:0] result_byte
  output logic [0:0]           out_tuser      // [0] overflow
);
  import cxtbc_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int VW = $clog2(TABLE_VALUE_MAX + 1);
  localparam int XW = 31 + VW;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_K0   = 3'd1;  // first key byte returning
  localparam logic [2:0] ST_K1   = 3'd2;  // second key byte returning
  localparam logic [2:0] ST_BMUL = 3'd3;  // generator multiply
  localparam logic [2:0] ST_BRED = 3'd4;  // generator reduction
  localparam logic [2:0] ST_BSCL = 3'd5;  // scale to table range
  localparam logic [2:0] ST_BWR  = 3'd6;  // table write
  localparam logic [2:0] ST_NOP  = 3'd7;  // zero result

  // Generator step as the Schrage formulation gives it, including its
  // answers for the all-zero and all-ones seeds.
  function automatic pm_word_t pm_reduce(input pm_word_t s,
                                         input logic [PM_PROD_W-1:0] p);
    logic [31:0] sum;
    pm_word_t    res;
    sum = {1'b0, p[30:0]} + 32'(p[PM_PROD_W-1:31]);
    if (sum >= {1'b0, PM_MODULUS}) begin
      sum = sum - {1'b0, PM_MODULUS};
    end
    res = sum[30:0];
    if (s == '0) begin
      res = PM_MODULUS;
    end else if (s == PM_MODULUS) begin
      res = PM_ONES_NEXT;
    end
    return res;
  endfunction

  // floor(x / (2^31-1)) for x below 2^40: with x = hi*2^31 + lo the
  // quotient is hi, plus one when hi + lo reaches the modulus.
  function automatic byte_t scale_div(input logic [XW-1:0] x);
    logic [31:0]   sum;
    logic [VW-1:0] q;
    sum = {1'b0, x[30:0]} + 32'(x[XW-1:31]);
    q   = x[XW-1:31] + VW'(sum >= {1'b0, PM_MODULUS});
    return 8'(q);
  endfunction

  // Control and state registers.
  logic [2:0]           state_r, state_nxt;
  pm_word_t             seed_r;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic                 wrap_r, wrap_nxt;
  byte_t                chain_r, chain_nxt;
  logic [IW-1:0]        bidx_r, bidx_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Per-word payload registers.
  byte_t                data_r, res_r, out_data_r;
  logic                 enc_r, out_ovf_r;
  logic [IW-1:0]        k1_r;
  pm_word_t             gen_r;
  logic [PM_PROD_W-1:0] prod_r;
  logic [XW-1:0]        scl_r;

  // Key memory with a registered read port.
  byte_t                key_mem [TABLE_DEPTH];
  byte_t                rd_data_r;
  logic                 rd_en, mem_we;
  logic [IW-1:0]        rd_addr;

  cmd_t                 in_cmd;
  logic                 in_first, acc, acc_cipher, out_free, emit;
  logic [IW-1:0]        base, k0, k1, k2;
  logic                 w1, w2;

  assign in_cmd   = in_tuser[1:0];
  assign in_first = in_tuser[2];
  assign out_free = !out_valid_r || out_tready;

  // A new word may enter while the previous byte delivers its result.
  assign in_tready  = (state_r == ST_IDLE) || ((state_r == ST_K1) && out_free);
  assign acc        = in_tvalid && in_tready;
  assign acc_cipher = acc && ((in_cmd == CMD_ENCIPHER) || (in_cmd == CMD_DECIPHER));
  assign emit       = ((state_r == ST_K1) || (state_r == ST_NOP)) && out_free;

  // Key indices for the byte being accepted; the index register is
  // advanced at acceptance so that a following word sees it at once.
  assign base = in_first ? '0 : idx_r;
  assign w1   = (base == LAST_IDX);
  assign k0   = base;
  assign k1   = w1 ? '0 : base + IW'(1);
  assign w2   = (k1 == LAST_IDX);
  assign k2   = w2 ? '0 : k1 + IW'(1);

  // Reads only come from message bytes and writes only from a build, and
  // the two never overlap, so no forwarding is needed.
  assign rd_en   = acc_cipher || (state_r == ST_K0);
  assign rd_addr = (state_r == ST_K0) ? k1_r : k0;
  assign mem_we  = (state_r == ST_BWR);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    wrap_nxt      = wrap_r;
    chain_nxt     = chain_r;
    bidx_nxt      = bidx_r;
    out_valid_nxt = out_valid_r;

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end

    unique case (state_r)
      ST_IDLE: ;
      ST_K0:   state_nxt = ST_K1;
      ST_K1: begin
        if (out_free) begin
          chain_nxt = (enc_r ? res_r : data_r) ^ rd_data_r;
          state_nxt = ST_IDLE;
        end
      end
      ST_BMUL: state_nxt = ST_BRED;
      ST_BRED: state_nxt = ST_BSCL;
      ST_BSCL: state_nxt = ST_BWR;
      ST_BWR: begin
        if (bidx_r == LAST_IDX) begin
          bidx_nxt  = '0;
          state_nxt = ST_NOP;
        end else begin
          bidx_nxt  = bidx_r + IW'(1);
          state_nxt = ST_BMUL;
        end
      end
      ST_NOP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (acc) begin
      unique case (in_cmd) inside
        CMD_ENCIPHER, CMD_DECIPHER: begin
          state_nxt = ST_K0;
          idx_nxt   = k2;
          wrap_nxt  = (wrap_r && !in_first) || w1 || w2;
          if (in_first) begin
            chain_nxt = '0;
          end
        end
        CMD_BUILD: state_nxt = ST_BMUL;
        default:   state_nxt = ST_NOP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seed_r      <= SEED_RESET;
      idx_r       <= '0;
      wrap_r      <= 1'b0;
      chain_r     <= '0;
      bidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      wrap_r      <= wrap_nxt;
      chain_r     <= chain_nxt;
      bidx_r      <= bidx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (acc_cipher) begin
      data_r <= in_tdata;
      enc_r  <= (in_cmd == CMD_ENCIPHER);
      k1_r   <= k1;
    end
    if (acc && (in_cmd == CMD_BUILD)) begin
      gen_r <= seed_r;
    end
    if (state_r == ST_K0) begin
      res_r <= data_r ^ rd_data_r ^ chain_r;
    end
    if (state_r == ST_BMUL) begin
      prod_r <= PM_PROD_W'(gen_r) * PM_PROD_W'(PM_MULT);
    end
    if (state_r == ST_BRED) begin
      gen_r <= pm_reduce(gen_r, prod_r);
    end
    if (state_r == ST_BSCL) begin
      scl_r <= XW'(gen_r) * XW'(TABLE_VALUE_MAX);
    end
    if (emit) begin
      out_data_r <= (state_r == ST_K1) ? res_r : '0;
      out_ovf_r  <= (state_r == ST_K1) ? wrap_r : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[bidx_r] <= scale_div(scl_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= key_mem[rd_addr];
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_ovf_r;

  // A message byte accepted goes straight to its first key read.
  a_cipher_start: assert property (@(posedge clk) disable iff (!rst_n)
    acc_cipher |=> state_r == ST_K0)
    else $error("message byte did not start its key reads");

  // The table index never leaves the table.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= LAST_IDX)
    else $error("table index beyond table end");

  // The overflow flag only clears on a byte that starts a message.
  a_wrap_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(wrap_r) |-> $past(acc_cipher && in_first))
    else $error("overflow flag cleared without a first byte");

  // A finishing byte with room on the result side always shows a result.
  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_K1 && out_free) |=> out_tvalid)
    else $error("finished byte produced no result word");

  // The build counter rests at zero outside a build.
  a_bidx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_K0 || state_r == ST_K1) |-> bidx_r == '0)
    else $error("build counter not at rest");

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the chained XOR key-table byte cipher.
// Drives the input stream and the seed port, predicts every result word and
// checks it; depends only on cxtbc_pkg and the cipher top level.
module testbench;
  import cxtbc_pkg::*;

  localparam int DEPTH       = TABLE_DEPTH_DEF;
  localparam int VALUE_MAX   = TABLE_VALUE_MAX_DEF;
  // A table build moves no word until its result comes out, so the watchdog
  // limit must exceed the length of a whole build.
  localparam int STALL_LIMIT = 20000;
  localparam int WORD_TARGET = 500;
  // The last words of the run are sent and taken with no idling at all.
  localparam int CALM_WORDS  = 60;
  localparam int MAX_RESEEDS = 4;

  typedef struct packed {
    byte_t result_byte;
    logic  overflow;
  } cipher_word_t;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       cfg_wr_en   = 1'b0;
  pm_word_t   cfg_wr_data = '0;
  logic       in_tvalid   = 1'b0;
  logic       in_tready;
  byte_t      in_tdata    = '0;   // [7:0] data_byte
  logic [2:0] in_tuser    = '0;   // [1:0] cmd, [2] first
  logic       out_tvalid;
  logic       out_tready  = 1'b0;
  byte_t      out_tdata;          // [7:0] result_byte
  logic [0:0] out_tuser;          // [0] overflow

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  chained_xor_table_byte_cipher i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  // ---------------------------------------------------------------------------
  // Prediction. The testbench keeps its own copy of the key table, the seed
  // register, the generator, the table position, the chain byte and the wrap
  // flag, and advances them as each word is accepted at the input.
  // ---------------------------------------------------------------------------
  byte_t    key_bytes [DEPTH];
  pm_word_t seed_start_r = SEED_RESET;
  pm_word_t gen_word     = SEED_RESET;
  int       key_pos      = 0;
  byte_t    chain_r      = '0;
  logic     wrap_r       = 1'b0;

  // One minimal-standard step, split Schrage-fashion so that nothing overflows.
  // A seed of zero or all ones lands on the modulus and stays there.
  function automatic pm_word_t pm_advance(pm_word_t s);
    longint hi;
    longint lo;
    longint acc;
    hi  = longint'(s) / PM_Q_L;
    lo  = longint'(s) % PM_Q_L;
    acc = PM_MULT_L * lo - PM_R_L * hi;
    if (acc <= 0) begin
      acc += PM_MODULUS_L;
    end
    return pm_word_t'(acc);
  endfunction

  // Each entry is the generator scaled to 0..VALUE_MAX, kept to its low byte;
  // only a stuck generator reaches VALUE_MAX itself, which then wraps to zero.
  function automatic void fill_key_table();
    longint scaled;
    gen_word = seed_start_r;
    for (int i = 0; i < DEPTH; i++) begin
      gen_word     = pm_advance(gen_word);
      scaled       = (longint'(gen_word) * VALUE_MAX) / PM_MODULUS_L;
      key_bytes[i] = byte_t'(scaled);
    end
  endfunction

  function automatic cipher_word_t cipher_step(cmd_t cmd, byte_t data, logic first);
    cipher_word_t r;
    int           k1;
    int           k2;
    r = '0;
    case (cmd) inside
      CMD_BUILD: begin
        // The first flag means nothing to a build and the message state is kept.
        fill_key_table();
      end
      CMD_ENCIPHER, CMD_DECIPHER: begin
        if (first) begin
          chain_r = '0;
          key_pos = 0;
          wrap_r  = 1'b0;
        end
        // The second key index and the next position may each step past the last entry; either wrap sets the flag.
        k1 = key_pos + 1;
        if (k1 >= DEPTH) begin
          k1     = 0;
          wrap_r = 1'b1;
        end
        k2 = k1 + 1;
        if (k2 >= DEPTH) begin
          k2     = 0;
          wrap_r = 1'b1;
        end
        r.result_byte = data ^ key_bytes[key_pos] ^ chain_r;
        // Enciphering chains on the cipher byte it produced, deciphering on
        // the cipher byte it received, so both sides carry the same chain.
        chain_r    = ((cmd == CMD_ENCIPHER) ? r.result_byte : data) ^ key_bytes[k1];
        key_pos    = k2;
        r.overflow = wrap_r;
      end
      default: begin
        // The unused command leaves every piece of state alone.
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking. Every word taken from the result channel is compared with
  // the oldest prediction still outstanding.
  // ---------------------------------------------------------------------------
  cipher_word_t result_words [$];
  int           bad_words      = 0;
  int           overflow_words = 0;

  always @(posedge clk) begin : result_check
    cipher_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (result_words.size() == 0) begin
        bad_words++;
        $display("%0t: result word with nothing outstanding: expected none, got %02h/%0b",
                 $time, out_tdata, out_tuser[0]);
      end else begin
        want = result_words.pop_front();
        if (out_tdata !== want.result_byte) begin
          bad_words++;
          $display("%0t: result_byte mismatch: expected %02h, got %02h",
                   $time, want.result_byte, out_tdata);
        end
        if (out_tuser[0] !== want.overflow) begin
          bad_words++;
          $display("%0t: overflow mismatch: expected %0b, got %0b",
                   $time, want.overflow, out_tuser[0]);
        end
        if (out_tuser[0] === 1'b1) begin
          overflow_words++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side back-pressure. While idling is allowed the ready line drops now
  // and then for a burst of random length; otherwise it stays high.
  // ---------------------------------------------------------------------------
  logic idle_on    = 1'b1;
  int   stall_left = 0;

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 16);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: counts cycles in which no word moves on either channel and no
  // seed is written, and abandons the run if that goes on too long.
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || cfg_wr_en || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("%0t: no word has moved for %0d cycles", $time, STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared sender. One word is offered, possibly after a random gap, and held
  // until it is accepted; the prediction is made at the accepting edge. The
  // valid line is left high so that back-to-back words can follow with no gap.
  // ---------------------------------------------------------------------------
  int words_sent   = 0;
  int enc_words    = 0;
  int dec_words    = 0;
  int build_words  = 0;
  int seeds_loaded = 0;

  task automatic send_word(cmd_t cmd, byte_t data, logic first);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= {first, cmd};
    do @(posedge clk); while (!in_tready);
    result_words.push_back(cipher_step(cmd, data, first));
    case (cmd)
      CMD_ENCIPHER: enc_words++;
      CMD_DECIPHER: dec_words++;
      CMD_BUILD:    build_words++;
      default:      ;
    endcase
    if (cmd != CMD_NONE) begin
      words_sent++;
    end
  endtask

  // Stops offering words and waits until every predicted result has arrived.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (result_words.size() != 0) @(posedge clk);
  endtask

  // The seed register is only touched with nothing in flight.
  task automatic write_seed(pm_word_t seed);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= seed;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    seed_start_r  = seed;
    seeds_loaded++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Before any table exists only the unused command may be sent, as it reads
  // nothing. The first build then runs from the seed value left by reset.
  task automatic test_before_build();
    send_word(CMD_NONE, 8'h00, 1'b1);
    send_word(CMD_NONE, 8'hff, 1'b0);
    send_word(CMD_BUILD, byte_t'($urandom), 1'b1);
  endtask

  // Extreme byte values in both directions, an unused word in the middle of
  // a message, and a rebuild that must leave the chain and position intact.
  task automatic test_directed_bytes();
    send_word(CMD_ENCIPHER, 8'h00, 1'b1);
    send_word(CMD_ENCIPHER, 8'hff, 1'b0);
    send_word(CMD_ENCIPHER, 8'ha5, 1'b0);
    send_word(CMD_DECIPHER, 8'hff, 1'b1);
    send_word(CMD_DECIPHER, 8'h00, 1'b0);
    send_word(CMD_NONE, 8'h5a, 1'b1);
    send_word(CMD_DECIPHER, 8'h3c, 1'b0);
    send_word(CMD_BUILD, 8'hff, 1'b1);
    send_word(CMD_ENCIPHER, 8'hc3, 1'b0);
  endtask

  // The lowest and highest seeds of the normal range, then the two seeds that
  // jam the generator at the modulus, where every key byte comes out zero.
  task automatic test_seed_extremes();
    pm_word_t seeds [4];
    seeds = '{31'd1, 31'h7ffffffe, 31'd0, 31'h7fffffff};
    foreach (seeds[i]) begin
      write_seed(seeds[i]);
      send_word(CMD_BUILD, byte_t'($urandom), 1'b0);
      send_word(CMD_ENCIPHER, byte_t'($urandom), 1'b1);
      send_word(CMD_DECIPHER, byte_t'($urandom), 1'b0);
    end
  endtask

  // One message long enough to run past the end of the table, so that the
  // position wraps and the overflow flag rises and then stays set.
  task automatic test_table_wrap();
    int   len;
    cmd_t mode;
    len  = DEPTH / 2 + $urandom_range(1, 24);
    mode = $urandom_range(0, 1) ? CMD_DECIPHER : CMD_ENCIPHER;
    write_seed(pm_word_t'($urandom));
    send_word(CMD_BUILD, byte_t'($urandom), 1'($urandom_range(0, 1)));
    for (int i = 0; i < len; i++) begin
      send_word(mode, byte_t'($urandom), i == 0);
    end
  endtask

  // Mostly well-formed messages of random length and direction, with some that
  // carry on from the previous chain, stray words of the other kind or of the
  // unused command, the odd pause for the result side to empty, and now and
  // then a fresh seed and table.
  task automatic test_random_messages();
    int   pick;
    int   len;
    int   reseeds;
    cmd_t mode;
    cmd_t other;
    logic starts;
    reseeds = 0;
    while (words_sent < WORD_TARGET) begin
      if (words_sent >= WORD_TARGET - CALM_WORDS) begin
        idle_on = 1'b0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 3 && reseeds < MAX_RESEEDS) begin
        reseeds++;
        write_seed(pm_word_t'($urandom));
        send_word(CMD_BUILD, byte_t'($urandom), 1'($urandom_range(0, 1)));
      end else if (pick < 6) begin
        wait_drained();
      end else begin
        len    = $urandom_range(1, 24);
        mode   = $urandom_range(0, 1) ? CMD_DECIPHER : CMD_ENCIPHER;
        other  = (mode == CMD_ENCIPHER) ? CMD_DECIPHER : CMD_ENCIPHER;
        starts = ($urandom_range(0, 9) != 0);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 15) == 0) begin
            send_word($urandom_range(0, 1) ? CMD_NONE : other,
                      byte_t'($urandom), 1'($urandom_range(0, 1)));
          end
          send_word(mode, byte_t'($urandom), (i == 0) ? starts : 1'b0);
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_before_build();
    test_directed_bytes();
    test_seed_extremes();
    test_table_wrap();
    test_random_messages();

    // Let the last results come in, then watch a little longer for any
    // word the block should never have produced.
    wait_drained();
    repeat (16) @(posedge clk);

    $display("Run covered %0d encipher, %0d decipher and %0d build words with %0d seeds loaded.",
             enc_words, dec_words, build_words, seeds_loaded);
    $display("%0d result words carried the overflow flag; %0d mismatches were found.",
             overflow_words, bad_words);
    if (bad_words == 0 && result_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
